/* src/mm4_pkg.sv */
// Shared constants, types and field layouts of the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    // Matrix geometry. The index split into row and column assumes DIM is a power of two.
    localparam int DIM    = 4;
    localparam int DIM_W  = $clog2(DIM);
    localparam int IDX_W  = 2 * DIM_W;

    // Signed Q16.16 operands, exact products and a sum of DIM products.
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + DIM_W;
    localparam int SH_W   = ACC_W - FRAC_W;

    typedef logic [DIM_W-1:0]         t_dim_idx;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // One element of C travelling down the chain with its partial sum.
    typedef struct packed {
        logic     valid;
        t_dim_idx row;
        t_dim_idx col;
        t_acc     psum;
    } t_token;

    // Load beat broadcast to every cell.
    typedef struct packed {
        logic     we;
        t_dim_idx row;
        t_dim_idx col;
        t_data    a_value;
        t_data    b_value;
    } t_load;

endpackage

/* src/mm4_cell.sv */
// One multiply-accumulate cell: holds column k of A and row k of B, adds one product per element.
module mm4_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mm4_pkg::t_dim_idx i_cell_id,
    input  mm4_pkg::t_load  i_load,
    input  mm4_pkg::t_token i_tok,
    output mm4_pkg::t_token o_tok
);
    import mm4_pkg::*;

    t_data  r_a [DIM];
    t_data  r_b [DIM];
    t_token r_s1;
    t_prod  r_prod;
    t_token r_s2;
    t_token n_s1;
    t_token n_s2;
    t_prod  n_prod;

    // Local slice of the matrices: A[row][k] lives at entry row, B[k][col] at entry col.
    always_ff @(posedge i_clk) begin
        if (i_load.we && (i_load.col == i_cell_id)) begin
            r_a[i_load.row] <= i_load.a_value;
        end
        if (i_load.we && (i_load.row == i_cell_id)) begin
            r_b[i_load.col] <= i_load.b_value;
        end
    end

    // First stage multiplies A[row][k] by B[k][col]; second stage adds it to the partial sum.
    always_comb begin
        n_prod = r_a[i_tok.row] * r_b[i_tok.col];
        n_s1   = i_tok;
        n_s2   = r_s1;
        n_s2.psum = r_s1.psum + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s1   <= n_s1;
            r_prod <= n_prod;
            r_s2   <= n_s2;
        end
    end

    assign o_tok = r_s2;

endmodule

/* src/matrix_multiply_4x4.sv */
// Top level of the 4x4 signed Q16.16 matrix multiplier with its chain of MAC cells.
//
// Each accepted beat loads A[i] and B[i]. The beat marked last also starts
// the product: sixteen elements of C enter a chain of four MAC cells, one
// element per cycle while the output is not stalled, each cell adding one
// product A[r][k]*B[k][c] in a multiply stage and then an accumulate stage.
// Results leave one per cycle while the output is not stalled, and an output
// stall holds the whole chain. Input is stalled from the last load beat until
// the final result has been taken. Each element is the exact sum of four
// products, floored to Q16.16 and clipped to 32 bits, with o_saturated set
// when clipping occurred.
module matrix_multiply_4x4 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mm4_pkg::t_idx        i_element_index,
    input  mm4_pkg::t_data       i_a_value,
    input  mm4_pkg::t_data       i_b_value,
    input  logic                 i_load_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mm4_pkg::t_idx        o_result_index,
    output mm4_pkg::t_data       o_result_value,
    output logic                 o_saturated,
    output logic                 o_result_last
);
    import mm4_pkg::*;

    logic     r_busy;
    logic     r_issuing;
    t_dim_idx r_row;
    t_dim_idx r_col;
    logic     r_out_valid;
    t_idx     r_out_index;
    t_data    r_out_value;
    logic     r_out_sat;
    logic     r_out_last;

    logic     w_in_acc;
    logic     w_out_acc;
    logic     w_en;
    logic     w_issue_end;
    t_load    w_load;
    t_token   w_tok [DIM+1];
    t_token   w_tail;

    logic [SH_W-1:0]          w_shifted;
    logic [SH_W-DATA_W:0]     w_guard;
    logic                     w_in_range;
    t_data                    n_out_value;
    logic                     n_out_sat;

    // Handshakes. The whole chain holds while a result waits on a stalled output.
    assign o_in_stall = r_busy;
    assign w_in_acc   = i_in_valid && !r_busy;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_en       = !(r_out_valid && i_out_stall);

    // Load beat broadcast to the cells.
    always_comb begin
        w_load.we      = w_in_acc;
        w_load.row     = i_element_index[IDX_W-1:DIM_W];
        w_load.col     = i_element_index[DIM_W-1:0];
        w_load.a_value = i_a_value;
        w_load.b_value = i_b_value;
    end

    // Element sequencer: walks C in row-major order, one element per enabled cycle.
    assign w_issue_end = (r_row == t_dim_idx'(DIM-1)) && (r_col == t_dim_idx'(DIM-1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issuing <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
        end else begin
            if (w_in_acc && i_load_last) begin
                r_busy    <= 1'b1;
                r_issuing <= 1'b1;
                r_row     <= '0;
                r_col     <= '0;
            end else if (w_en && r_issuing) begin
                if (w_issue_end) begin
                    r_issuing <= 1'b0;
                end
                if (r_col == t_dim_idx'(DIM-1)) begin
                    r_col <= '0;
                    r_row <= r_row + t_dim_idx'(1);
                end else begin
                    r_col <= r_col + t_dim_idx'(1);
                end
            end
            if (w_out_acc && r_out_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Head of the chain starts every element with an empty partial sum.
    always_comb begin
        w_tok[0].valid = r_issuing;
        w_tok[0].row   = r_row;
        w_tok[0].col   = r_col;
        w_tok[0].psum  = '0;
    end

    // Chain of MAC cells, cell k adding the k-th product of each dot product.
    for (genvar g = 0; g < DIM; g++) begin : g_cell
        mm4_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_cell_id (t_dim_idx'(g)),
            .i_load    (w_load),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[DIM];

    // Floor to Q16.16 and clip to the signed 32-bit range.
    always_comb begin
        w_shifted  = w_tail.psum[ACC_W-1:FRAC_W];
        w_guard    = w_shifted[SH_W-1:DATA_W-1];
        w_in_range = (&w_guard) || !(|w_guard);
        n_out_sat  = !w_in_range;
        if (w_in_range) begin
            n_out_value = w_shifted[DATA_W-1:0];
        end else if (w_shifted[SH_W-1]) begin
            n_out_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_out_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tail.valid) begin
            r_out_index <= {w_tail.row, w_tail.col};
            r_out_value <= n_out_value;
            r_out_sat   <= n_out_sat;
            r_out_last  <= (w_tail.row == t_dim_idx'(DIM-1)) &&
                           (w_tail.col == t_dim_idx'(DIM-1));
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_result_value = r_out_value;
    assign o_saturated    = r_out_sat;
    assign o_result_last  = r_out_last;

    // A result is only ever shown while a job is in progress.
    a_out_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_busy)
        else $error("result shown outside a job");

    // The final element leaves only after the sequencer has stopped issuing.
    a_last_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_issuing)
        else $error("final result while elements still being issued");

    // Taking a result that is not the final one keeps the job open.
    a_job_stays_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !r_out_last) |=> r_busy)
        else $error("job closed before the final result");

    // Issuing only happens inside a job.
    a_issue_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> r_busy)
        else $error("element issued outside a job");

endmodule
